// ===== sv/atcp_pkg.sv =====
`default_nettype none

package atcp_pkg;

    localparam int LINE_LEN_DEF = 32;
    localparam int MAX_RESULTS  = 32;
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);
    localparam int ROM_AW       = 6;

    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_H  = 8'h48;
    localparam logic [7:0] CH_I  = 8'h49;
    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_T  = 8'h54;
    localparam logic [7:0] CH_Z  = 8'h5A;

    localparam logic [1:0] LINK_IDLE      = 2'd0;
    localparam logic [1:0] LINK_CONNECTED = 2'd1;

    typedef enum logic [1:0] {KIND_HOST, KIND_ACTION, KIND_DIGIT, KIND_BUSY} kind_t;
    typedef enum logic [1:0] {ACT_DIAL, ACT_ANSWER, ACT_HANGUP} action_t;
    typedef enum logic [1:0] {MODE_CMD, MODE_WAIT, MODE_CONN} mode_t;

    typedef enum logic [2:0] {
        MATCH_NONE, MATCH_DIAL, MATCH_IDENT, MATCH_OK, MATCH_ANSWER, MATCH_HANGUP
    } match_t;

    typedef enum logic [2:0] {
        TXT_CRLF, TXT_ERASE, TXT_IDENT, TXT_OK, TXT_ERROR, TXT_CONNECT
    } text_t;

    typedef enum logic [2:0] {
        SRC_TEXT, SRC_CHAR, SRC_BUSY, SRC_ACTION, SRC_DIGIT
    } src_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECIDE, ST_ECHO, ST_BUSY, ST_TEXT, ST_DISPATCH, ST_ACTION, ST_DIGITS
    } state_t;

    typedef struct packed {
        logic   accept;
        logic   store_char;
        logic   len_dec;
        logic   line_end;
        logic   load_text;
        text_t  text_id;
        logic   text_adv;
        logic   emit;
        src_t   emit_src;
        logic   emit_last;
        logic   digit_adv;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       is_link;
        logic       is_eol;
        logic       is_bs;
        logic       len_zero;
        logic       len_full;
        logic [1:0] link_state;
        match_t     match_now;
        match_t     match_line;
        logic       text_done;
        logic       dig_empty;
        logic       dig_last;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    // Response texts, each LF already preceded by CR.
    function automatic logic [7:0] rom_byte(input logic [ROM_AW-1:0] a);
        logic [7:0] r;
        unique case (a)
            6'd0:    r = 8'h0D;
            6'd1:    r = 8'h0A;
            6'd2:    r = 8'h08;
            6'd3:    r = 8'h20;
            6'd4:    r = 8'h08;
            6'd5:    r = 8'h41;
            6'd6:    r = 8'h54;
            6'd7:    r = 8'h20;
            6'd8:    r = 8'h4D;
            6'd9:    r = 8'h4F;
            6'd10:   r = 8'h44;
            6'd11:   r = 8'h45;
            6'd12:   r = 8'h4D;
            6'd13:   r = 8'h20;
            6'd14:   r = 8'h31;
            6'd15:   r = 8'h2E;
            6'd16:   r = 8'h30;
            6'd17:   r = 8'h0D;
            6'd18:   r = 8'h0A;
            6'd19:   r = 8'h4F;
            6'd20:   r = 8'h4B;
            6'd21:   r = 8'h0D;
            6'd22:   r = 8'h0A;
            6'd23:   r = 8'h45;
            6'd24:   r = 8'h52;
            6'd25:   r = 8'h52;
            6'd26:   r = 8'h4F;
            6'd27:   r = 8'h52;
            6'd28:   r = 8'h0D;
            6'd29:   r = 8'h0A;
            6'd30:   r = 8'h43;
            6'd31:   r = 8'h4F;
            6'd32:   r = 8'h4E;
            6'd33:   r = 8'h4E;
            6'd34:   r = 8'h45;
            6'd35:   r = 8'h43;
            6'd36:   r = 8'h54;
            6'd37:   r = 8'h0D;
            6'd38:   r = 8'h0A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [ROM_AW-1:0] text_first(input text_t t);
        logic [ROM_AW-1:0] r;
        unique case (t)
            TXT_CRLF:    r = 6'd0;
            TXT_ERASE:   r = 6'd2;
            TXT_IDENT:   r = 6'd5;
            TXT_OK:      r = 6'd19;
            TXT_ERROR:   r = 6'd23;
            TXT_CONNECT: r = 6'd30;
            default:     r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [ROM_AW-1:0] text_final(input text_t t);
        logic [ROM_AW-1:0] r;
        unique case (t)
            TXT_CRLF:    r = 6'd1;
            TXT_ERASE:   r = 6'd4;
            TXT_IDENT:   r = 6'd18;
            TXT_OK:      r = 6'd22;
            TXT_ERROR:   r = 6'd29;
            TXT_CONNECT: r = 6'd38;
            default:     r = 6'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/atcp_ctrl.sv =====
`default_nettype none

module atcp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire atcp_pkg::dp_stat_t stat,
    output atcp_pkg::ctrl_cmd_t    cmd
);

    atcp_pkg::state_t state_reg, state_next;
    atcp_pkg::mode_t  mode_reg, mode_next;
    logic             cont_reg, cont_next;
    logic             dial_more;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= atcp_pkg::ST_IDLE;
            mode_reg  <= atcp_pkg::MODE_CMD;
            cont_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cont_reg  <= cont_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        cont_next     = cont_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.text_id   = atcp_pkg::TXT_CRLF;
        cmd.emit_src  = atcp_pkg::SRC_TEXT;
        dial_more     = (stat.match_line == atcp_pkg::MATCH_DIAL) && !stat.dig_empty;

        unique case (state_reg)
            atcp_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = atcp_pkg::ST_DECIDE;
                end
            end

            atcp_pkg::ST_DECIDE: begin
                cont_next  = 1'b0;
                state_next = atcp_pkg::ST_IDLE;
                if (stat.is_link) begin
                    unique case (mode_reg)
                        atcp_pkg::MODE_WAIT: begin
                            if (stat.link_state == atcp_pkg::LINK_IDLE) begin
                                cmd.load_text = 1'b1;
                                cmd.text_id   = atcp_pkg::TXT_ERROR;
                                mode_next     = atcp_pkg::MODE_CMD;
                                state_next    = atcp_pkg::ST_TEXT;
                            end else if (stat.link_state == atcp_pkg::LINK_CONNECTED) begin
                                cmd.load_text = 1'b1;
                                cmd.text_id   = atcp_pkg::TXT_CONNECT;
                                mode_next     = atcp_pkg::MODE_CONN;
                                state_next    = atcp_pkg::ST_TEXT;
                            end
                        end
                        atcp_pkg::MODE_CONN: begin
                            if (stat.link_state == atcp_pkg::LINK_IDLE) begin
                                cmd.load_text = 1'b1;
                                cmd.text_id   = atcp_pkg::TXT_OK;
                                mode_next     = atcp_pkg::MODE_CMD;
                                state_next    = atcp_pkg::ST_TEXT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (mode_reg != atcp_pkg::MODE_CMD) begin
                    state_next = atcp_pkg::ST_BUSY;
                end else if (stat.is_eol) begin
                    if (!stat.len_zero) begin
                        cmd.line_end  = 1'b1;
                        cmd.load_text = 1'b1;
                        cmd.text_id   = atcp_pkg::TXT_CRLF;
                        cont_next     = (stat.match_now != atcp_pkg::MATCH_NONE);
                        state_next    = atcp_pkg::ST_TEXT;
                    end
                end else if (stat.is_bs) begin
                    if (!stat.len_zero) begin
                        cmd.len_dec   = 1'b1;
                        cmd.load_text = 1'b1;
                        cmd.text_id   = atcp_pkg::TXT_ERASE;
                        state_next    = atcp_pkg::ST_TEXT;
                    end
                end else if (!stat.len_full) begin
                    cmd.store_char = 1'b1;
                    state_next     = atcp_pkg::ST_ECHO;
                end
            end

            atcp_pkg::ST_ECHO: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = atcp_pkg::SRC_CHAR;
                    cmd.emit_last = 1'b1;
                    state_next    = atcp_pkg::ST_IDLE;
                end
            end

            atcp_pkg::ST_BUSY: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = atcp_pkg::SRC_BUSY;
                    cmd.emit_last = 1'b1;
                    state_next    = atcp_pkg::ST_IDLE;
                end
            end

            atcp_pkg::ST_TEXT: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_src = atcp_pkg::SRC_TEXT;
                    if (stat.text_done) begin
                        // After the CR LF of a recognized command more results follow.
                        cmd.emit_last = !cont_reg;
                        state_next    = cont_reg ? atcp_pkg::ST_DISPATCH : atcp_pkg::ST_IDLE;
                    end else begin
                        cmd.text_adv = 1'b1;
                    end
                end
            end

            atcp_pkg::ST_DISPATCH: begin
                cont_next  = 1'b0;
                state_next = atcp_pkg::ST_IDLE;
                unique case (stat.match_line)
                    atcp_pkg::MATCH_DIAL, atcp_pkg::MATCH_ANSWER: begin
                        mode_next  = atcp_pkg::MODE_WAIT;
                        state_next = atcp_pkg::ST_ACTION;
                    end
                    atcp_pkg::MATCH_HANGUP: begin
                        state_next = atcp_pkg::ST_ACTION;
                    end
                    atcp_pkg::MATCH_IDENT: begin
                        cmd.load_text = 1'b1;
                        cmd.text_id   = atcp_pkg::TXT_IDENT;
                        state_next    = atcp_pkg::ST_TEXT;
                    end
                    atcp_pkg::MATCH_OK: begin
                        cmd.load_text = 1'b1;
                        cmd.text_id   = atcp_pkg::TXT_OK;
                        state_next    = atcp_pkg::ST_TEXT;
                    end
                    default: begin
                    end
                endcase
            end

            atcp_pkg::ST_ACTION: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = atcp_pkg::SRC_ACTION;
                    cmd.emit_last = !dial_more;
                    state_next    = dial_more ? atcp_pkg::ST_DIGITS : atcp_pkg::ST_IDLE;
                end
            end

            atcp_pkg::ST_DIGITS: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_src  = atcp_pkg::SRC_DIGIT;
                    cmd.emit_last = stat.dig_last;
                    cmd.digit_adv = 1'b1;
                    if (stat.dig_last) begin
                        state_next = atcp_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = atcp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/atcp_datapath.sv =====
`default_nettype none

module atcp_datapath #(
    parameter int LINE_LEN = atcp_pkg::LINE_LEN_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_command,
    input  wire logic [7:0]          in_char,
    input  wire logic [1:0]          in_link,
    input  wire logic                cfg_we,
    input  wire logic                cfg_bit,
    input  wire atcp_pkg::ctrl_cmd_t cmd,
    output atcp_pkg::dp_stat_t       stat,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output atcp_pkg::kind_t          out_kind,
    output logic [7:0]               out_byte,
    output atcp_pkg::action_t        out_action,
    output logic                     out_pulse,
    output logic                     out_last
);

    localparam int LEN_W  = $clog2(LINE_LEN + 1);
    localparam int ADDR_W = $clog2(LINE_LEN);
    localparam int HEAD_N = 5;

    logic                      cmd_bit_reg;
    logic [7:0]                char_reg;
    logic [1:0]                link_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [7:0]                head_reg [HEAD_N];
    logic [7:0]                mem [LINE_LEN];
    logic [7:0]                rdata_reg;
    atcp_pkg::match_t          match_reg;
    logic                      pulse_reg;
    logic [LEN_W-1:0]          pos_reg, pos_next;
    logic [LEN_W-1:0]          end_reg;
    logic [atcp_pkg::ROM_AW-1:0] txt_ptr_reg, txt_end_reg;
    logic [atcp_pkg::RES_W-1:0]  res_cnt_reg;
    logic                      dflt_pulse_reg;
    logic                      out_valid_reg;
    atcp_pkg::kind_t           out_kind_reg, out_kind_next;
    logic [7:0]                out_byte_reg, out_byte_next;
    atcp_pkg::action_t         out_action_reg, out_action_next;
    logic                      out_pulse_reg, out_pulse_next;
    logic                      out_last_reg;

    logic                      at_hit, p_hit, t_hit, pulse_now;
    logic [7:0]                t_char;
    atcp_pkg::match_t          match_now;
    logic [LEN_W-1:0]          start_pos;

    // Command recognition works on the first five characters, kept in flip-flops.
    always_comb begin
        at_hit = (len_reg >= LEN_W'(3))
              && (atcp_pkg::fold(head_reg[0]) == atcp_pkg::CH_A)
              && (atcp_pkg::fold(head_reg[1]) == atcp_pkg::CH_T);
        match_now = atcp_pkg::MATCH_NONE;
        if (at_hit) begin
            priority case (atcp_pkg::fold(head_reg[2]))
                atcp_pkg::CH_D: match_now = atcp_pkg::MATCH_DIAL;
                atcp_pkg::CH_I: match_now = atcp_pkg::MATCH_IDENT;
                atcp_pkg::CH_Z: match_now = atcp_pkg::MATCH_OK;
                atcp_pkg::CH_A: match_now = atcp_pkg::MATCH_ANSWER;
                atcp_pkg::CH_H: match_now = atcp_pkg::MATCH_HANGUP;
                default:        match_now = atcp_pkg::MATCH_NONE;
            endcase
        end
        p_hit  = (len_reg >= LEN_W'(4)) && (atcp_pkg::fold(head_reg[3]) == atcp_pkg::CH_P);
        t_char = p_hit ? head_reg[4] : head_reg[3];
        t_hit  = (len_reg >= (p_hit ? LEN_W'(5) : LEN_W'(4)))
              && (atcp_pkg::fold(t_char) == atcp_pkg::CH_T);
        pulse_now = t_hit ? 1'b0 : (p_hit ? 1'b1 : dflt_pulse_reg);
        start_pos = LEN_W'(3) + LEN_W'(p_hit) + LEN_W'(t_hit);
    end

    always_comb begin
        pos_next = pos_reg;
        if (cmd.line_end) begin
            pos_next = start_pos;
        end else if (cmd.digit_adv) begin
            pos_next = pos_reg + LEN_W'(1);
        end
    end

    always_comb begin
        stat.is_link    = cmd_bit_reg;
        stat.is_eol     = (char_reg == atcp_pkg::CH_CR) || (char_reg == atcp_pkg::CH_LF);
        stat.is_bs      = (char_reg == atcp_pkg::CH_BS);
        stat.len_zero   = (len_reg == '0);
        stat.len_full   = (len_reg == LEN_W'(LINE_LEN));
        stat.link_state = link_reg;
        stat.match_now  = match_now;
        stat.match_line = match_reg;
        stat.text_done  = (txt_ptr_reg == txt_end_reg);
        stat.dig_empty  = (pos_reg >= end_reg);
        stat.dig_last   = ((pos_reg + LEN_W'(1)) == end_reg)
                       || (res_cnt_reg == atcp_pkg::RES_W'(atcp_pkg::MAX_RESULTS - 1));
        stat.out_free   = !out_valid_reg || out_ready;
    end

    always_comb begin
        out_kind_next   = atcp_pkg::KIND_HOST;
        out_byte_next   = 8'h00;
        out_action_next = atcp_pkg::ACT_DIAL;
        out_pulse_next  = 1'b0;
        unique case (cmd.emit_src)
            atcp_pkg::SRC_TEXT: begin
                out_byte_next = atcp_pkg::rom_byte(txt_ptr_reg);
            end
            atcp_pkg::SRC_CHAR: begin
                out_byte_next = char_reg;
            end
            atcp_pkg::SRC_BUSY: begin
                out_kind_next = atcp_pkg::KIND_BUSY;
                out_byte_next = char_reg;
            end
            atcp_pkg::SRC_ACTION: begin
                out_kind_next = atcp_pkg::KIND_ACTION;
                unique case (match_reg)
                    atcp_pkg::MATCH_DIAL: begin
                        out_action_next = atcp_pkg::ACT_DIAL;
                        out_pulse_next  = pulse_reg;
                    end
                    atcp_pkg::MATCH_ANSWER: out_action_next = atcp_pkg::ACT_ANSWER;
                    default:                out_action_next = atcp_pkg::ACT_HANGUP;
                endcase
            end
            atcp_pkg::SRC_DIGIT: begin
                out_kind_next = atcp_pkg::KIND_DIGIT;
                out_byte_next = rdata_reg;
            end
            default: begin
            end
        endcase
    end

    // Line buffer: written one character at a time, read with a registered port
    // that follows the digit pointer.
    always_ff @(posedge aclk) begin
        if (cmd.store_char) begin
            mem[len_reg[ADDR_W-1:0]] <= char_reg;
        end
        rdata_reg <= mem[pos_next[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_bit_reg <= in_command;
            char_reg    <= in_char;
            link_reg    <= in_link;
        end
        for (int i = 0; i < HEAD_N; i++) begin
            if (cmd.store_char && (len_reg == LEN_W'(i))) begin
                head_reg[i] <= char_reg;
            end
        end
        if (cmd.line_end) begin
            match_reg <= match_now;
            pulse_reg <= pulse_now;
            end_reg   <= len_reg;
        end
        pos_reg <= pos_next;
        if (cmd.load_text) begin
            txt_ptr_reg <= atcp_pkg::text_first(cmd.text_id);
            txt_end_reg <= atcp_pkg::text_final(cmd.text_id);
        end else if (cmd.text_adv) begin
            txt_ptr_reg <= txt_ptr_reg + atcp_pkg::ROM_AW'(1);
        end
        if (cmd.emit) begin
            out_last_reg   <= cmd.emit_last;
            out_kind_reg   <= out_kind_next;
            out_byte_reg   <= out_byte_next;
            out_action_reg <= out_action_next;
            out_pulse_reg  <= out_pulse_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg        <= '0;
            res_cnt_reg    <= '0;
            dflt_pulse_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                dflt_pulse_reg <= cfg_bit;
            end
            if (cmd.line_end) begin
                len_reg <= '0;
            end else if (cmd.store_char) begin
                len_reg <= len_reg + LEN_W'(1);
            end else if (cmd.len_dec) begin
                len_reg <= len_reg - LEN_W'(1);
            end
            if (cmd.accept) begin
                res_cnt_reg <= '0;
            end else if (cmd.emit) begin
                res_cnt_reg <= res_cnt_reg + atcp_pkg::RES_W'(1);
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_byte   = out_byte_reg;
    assign out_action = out_action_reg;
    assign out_pulse  = out_pulse_reg;
    assign out_last   = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/at_command_line_parser_top.sv =====
`default_nettype none

// AT command line editor, modem side. Host characters and link state reports
// enter on the s_ stream, one transfer per item; every byte, modem action, dial
// digit or busy refusal that an item causes leaves on the m_ stream, with
// m_tlast on the final one. Items are handled one at a time: a transfer is
// taken only when the previous item's results have all been handed to the
// output register. An item is taken in the idle state and decoded in the
// decide state; its results then leave one per cycle while m_tready stays high,
// with the dispatch state between the CR LF echo and the rest of a recognized
// command line, and a character echo passes the idle, decide and echo states.
// Dial digits are read back from the line buffer memory through its registered
// read port, one per cycle while m_tready stays high. The dial method register
// (cfg_data) is always ready and must be written only while the block is idle.
module at_command_line_parser_top #(
    parameter int LINE_LEN = atcp_pkg::LINE_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] char_byte, [9:8] link_state, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [9:8] action, [10] pulse_select
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data   // default_pulse
);

    atcp_pkg::ctrl_cmd_t cmd;
    atcp_pkg::dp_stat_t  stat;
    atcp_pkg::kind_t     out_kind;
    logic [7:0]          out_byte;
    atcp_pkg::action_t   out_action;
    logic                out_pulse;

    assign cfg_ready = 1'b1;

    atcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    atcp_datapath #(
        .LINE_LEN (LINE_LEN)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_command (s_tuser[0]),
        .in_char    (s_tdata[7:0]),
        .in_link    (s_tdata[9:8]),
        .cfg_we     (cfg_valid),
        .cfg_bit    (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .out_action (out_action),
        .out_pulse  (out_pulse),
        .out_last   (m_tlast)
    );

    assign m_tdata = {5'b00000, out_pulse, out_action, out_byte};
    assign m_tuser = out_kind;

endmodule

`default_nettype wire
